[hw/rtl/rau_pkg.sv]
// Package for the rational arithmetic unit.
// Holds the operation codes, the sequencer state type and the default operand width.
package rau_pkg;

	localparam int OperandBitsDefault = 16;
	localparam int NumOutBits = 34;
	localparam int DenOutBits = 33;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GCD1,
		ST_LCM_DIV,
		ST_LCM_MUL,
		ST_SCALE_L,
		ST_SCALE_R,
		ST_SUM,
		ST_GCD2,
		ST_RED_NUM,
		ST_RED_DEN,
		ST_MUL_A,
		ST_MUL_B,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: add, subtract, multiply and divide of two fractions.
// A zero denominator, or a zero right numerator on divide, goes straight to the result.
// Multiply and divide form both parts on the multiplier; add and subtract run a gcd,
// an lcm, the scaling of both numerators, a sum, a second gcd and the reduction.
// Throughput: one item at a time; the next beat is taken in the cycle after the result leaves.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops valid.
module rational_arithmetic_unit_top #(
	parameter int OPERAND_BITS = rau_pkg::OperandBitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// operation[1:0], left_num, left_den, right_num, right_den, zero padding
	input  logic [((2+4*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// result_num[33:0], result_den[66:34], zero padding
	output logic [71:0]                 m_axis_tdata,
	// zero_den_error
	output logic                        m_axis_tuser
);
	import rau_pkg::*;

	localparam int W = OPERAND_BITS;
	localparam int M = 2 * W;          // width of products and of the lcm
	localparam int CW = $clog2(M + 1);
	localparam int IW = ((2 + 4 * W + 7) / 8) * 8;

	state_t state_q, state_d;
	op_t op_q;
	logic ln_neg_q, rn_neg_q;
	logic [W-1:0] ln_mag_q, rn_mag_q, ld_q, rd_q;
	// Working registers shared across steps.
	logic [M+1:0] a_q, b_q;  // gcd operands, also reused as scaled numerators
	logic [M-1:0] lcm_q;
	logic sa_neg_q, sb_neg_q;
	logic [M+1:0] s_mag_q;
	logic s_neg_q;
	logic [M+1:0] g_q;
	logic [M+1:0] num_mag_q;
	logic [M-1:0] den_mag_q;
	logic num_neg_q, den_neg_q;
	logic err_q;

	// Shared restoring divider: quotient and remainder of dvd_q / dvs_q.
	// div_done is high for the cycle after the last step, when quo_q and rem_q are final.
	logic div_busy_q, div_start, div_done, div_done_q;
	logic [M+1:0] dvd_q, dvs_q, quo_q, rem_q;
	logic [CW:0] cnt_q;
	logic [M+1:0] div_a, div_b;

	logic [W-1:0] in_ln, in_ld, in_rn, in_rd;
	logic accept;

	assign in_ln = s_axis_tdata[2 +: W];
	assign in_ld = s_axis_tdata[2+W +: W];
	assign in_rn = s_axis_tdata[2+2*W +: W];
	assign in_rd = s_axis_tdata[2+3*W +: W];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	// Shared multiplier, registered at its users. Every factor fits in W bits.
	logic [W-1:0] mul_a, mul_b;
	logic [M-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LCM_MUL: begin
				mul_a = quo_q[W-1:0];
				mul_b = rd_q;
			end
			ST_SCALE_L: begin
				mul_a = ln_mag_q;
				mul_b = quo_q[W-1:0];
			end
			ST_SCALE_R: begin
				mul_a = rn_mag_q;
				mul_b = quo_q[W-1:0];
			end
			ST_MUL_A: begin
				mul_a = ln_mag_q;
				mul_b = (op_q == OP_MUL) ? rn_mag_q : rd_q;
			end
			ST_MUL_B: begin
				mul_a = ld_q;
				mul_b = (op_q == OP_MUL) ? rd_q : rn_mag_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			div_done_q <= div_busy_q && (cnt_q == (CW+1)'(1));
			if (div_start) begin
				div_busy_q <= 1'b1;
				cnt_q <= (CW+1)'(M + 2);
				dvd_q <= div_a;
				dvs_q <= div_b;
				rem_q <= '0;
				quo_q <= '0;
			end else if (div_busy_q) begin
				if ({1'b0, rem_q[M:0], dvd_q[M+1]} >= {1'b0, dvs_q}) begin
					rem_q <= M'(0) + ({rem_q[M:0], dvd_q[M+1]} - dvs_q);
					quo_q <= {quo_q[M:0], 1'b1};
				end else begin
					rem_q <= {rem_q[M:0], dvd_q[M+1]};
					quo_q <= {quo_q[M:0], 1'b0};
				end
				dvd_q <= {dvd_q[M:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == (CW+1)'(1))
					div_busy_q <= 1'b0;
			end
		end
	end
	assign div_done = div_done_q;

	// Euclid runs on the divider: a gets b, b gets a mod b until b is zero.
	logic gcd_zero;
	assign gcd_zero = (b_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept) begin
					if (in_ld == '0 || in_rd == '0 ||
						(s_axis_tdata[1:0] == OP_DIV && in_rn == '0))
						state_d = ST_DONE;
					else if (s_axis_tdata[1:0] == OP_ADD || s_axis_tdata[1:0] == OP_SUB)
						state_d = ST_GCD1;
					else
						state_d = ST_MUL_A;
				end
			ST_GCD1:    if (gcd_zero && !div_busy_q) state_d = ST_LCM_DIV;
			ST_LCM_DIV: if (div_done) state_d = ST_LCM_MUL;
			ST_LCM_MUL: state_d = ST_SCALE_L;
			ST_SCALE_L: if (div_done) state_d = ST_SCALE_R;
			ST_SCALE_R: if (div_done) state_d = ST_SUM;
			ST_SUM:     state_d = ST_GCD2;
			ST_GCD2:    if (gcd_zero && !div_busy_q) state_d = ST_RED_NUM;
			ST_RED_NUM: if (div_done) state_d = ST_RED_DEN;
			ST_RED_DEN: if (div_done) state_d = ST_DONE;
			ST_MUL_A:   state_d = ST_MUL_B;
			ST_MUL_B:   state_d = ST_DONE;
			ST_DONE:    if (m_axis_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Divider launch: operands per step; runs once when idle, gcd steps rerun until b is 0.
	logic div_ran_q;
	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = '1;
		unique case (state_q)
			ST_GCD1, ST_GCD2: begin
				div_start = !div_busy_q && !div_done && !gcd_zero;
				div_a = a_q;
				div_b = b_q;
			end
			ST_LCM_DIV: begin
				div_start = !div_busy_q && !div_ran_q;
				div_a = (M+2)'(ld_q);
				div_b = g_q;
			end
			ST_SCALE_L: begin
				div_start = !div_busy_q && !div_ran_q;
				div_a = (M+2)'(lcm_q);
				div_b = (M+2)'(ld_q);
			end
			ST_SCALE_R: begin
				div_start = !div_busy_q && !div_ran_q;
				div_a = (M+2)'(lcm_q);
				div_b = (M+2)'(rd_q);
			end
			ST_RED_NUM: begin
				div_start = !div_busy_q && !div_ran_q;
				div_a = s_mag_q;
				div_b = g_q;
			end
			ST_RED_DEN: begin
				div_start = !div_busy_q && !div_ran_q;
				div_a = (M+2)'(lcm_q);
				div_b = g_q;
			end
			default: begin
				div_start = 1'b0;
				div_a = '0;
				div_b = '1;
			end
		endcase
	end

	logic [M+2:0] sum_same, diff_ab, diff_ba;
	assign sum_same = {1'b0, a_q} + {1'b0, b_q};
	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = {1'b0, b_q} - {1'b0, a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_ran_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				div_ran_q <= 1'b0;
			else if (div_start)
				div_ran_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE:
				if (accept) begin
					op_q <= op_t'(s_axis_tdata[1:0]);
					ln_neg_q <= in_ln[W-1];
					rn_neg_q <= in_rn[W-1];
					ln_mag_q <= in_ln[W-1] ? (~in_ln + 1'b1) : in_ln;
					rn_mag_q <= in_rn[W-1] ? (~in_rn + 1'b1) : in_rn;
					ld_q <= in_ld;
					rd_q <= in_rd;
					a_q <= (M+2)'(in_ld);
					b_q <= (M+2)'(in_rd);
					err_q <= (in_ld == '0 || in_rd == '0 ||
						(s_axis_tdata[1:0] == OP_DIV && in_rn == '0));
					num_mag_q <= '0;
					den_mag_q <= '0;
					num_neg_q <= 1'b0;
					den_neg_q <= 1'b0;
				end
			ST_GCD1, ST_GCD2:
				if (div_done) begin
					a_q <= b_q;
					b_q <= rem_q;
				end else if (gcd_zero && !div_busy_q) begin
					g_q <= a_q;
				end
			ST_LCM_MUL: lcm_q <= mul_p;
			ST_SCALE_L:
				if (div_done) begin
					a_q <= (M+2)'(mul_p);
					sa_neg_q <= ln_neg_q;
				end
			ST_SCALE_R:
				if (div_done) begin
					b_q <= (M+2)'(mul_p);
					sb_neg_q <= (rn_neg_q ^ (op_q == OP_SUB));
				end
			ST_SUM: begin
				if (sa_neg_q == sb_neg_q) begin
					s_mag_q <= sum_same[M+1:0];
					s_neg_q <= sa_neg_q;
				end else if (a_q >= b_q) begin
					s_mag_q <= diff_ab[M+1:0];
					s_neg_q <= sa_neg_q;
				end else begin
					s_mag_q <= diff_ba[M+1:0];
					s_neg_q <= sb_neg_q;
				end
				a_q <= (sa_neg_q == sb_neg_q) ? sum_same[M+1:0] :
					(a_q >= b_q) ? diff_ab[M+1:0] : diff_ba[M+1:0];
				b_q <= (M+2)'(lcm_q);
			end
			ST_RED_NUM:
				if (div_done) begin
					num_mag_q <= quo_q;
					num_neg_q <= s_neg_q && (quo_q != '0);
				end
			ST_RED_DEN:
				if (div_done)
					den_mag_q <= quo_q[M-1:0];
			ST_MUL_A: begin
				num_mag_q <= (M+2)'(mul_p);
				num_neg_q <= (op_q == OP_MUL) ? (ln_neg_q ^ rn_neg_q) : ln_neg_q;
			end
			ST_MUL_B: begin
				den_mag_q <= mul_p;
				den_neg_q <= (op_q == OP_DIV) && rn_neg_q;
			end
			default: ;
		endcase
	end

	// The lcm step reuses g_q from the first gcd; the scale steps divide lcm by each den.
	logic [71:0] num_w, den_w;
	assign num_w = 72'(num_mag_q);
	assign den_w = 72'(den_mag_q);

	logic [NumOutBits-1:0] rnum;
	logic [DenOutBits-1:0] rden;
	always_comb begin
		rnum = (num_neg_q && num_mag_q != '0) ? NumOutBits'(~num_w + 1'b1)
			: NumOutBits'(num_w);
		rden = den_neg_q ? DenOutBits'(~den_w + 1'b1) : DenOutBits'(den_w);
		if (err_q) begin
			rnum = '0;
			rden = '0;
		end
	end

	assign m_axis_tvalid = (state_q == ST_DONE);
	assign m_axis_tdata = {5'd0, rden, rnum};
	assign m_axis_tuser = err_q;

	logic unused_in;
	assign unused_in = ^{s_axis_tdata[IW-1:0], lcm_q[0]};

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result held");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_busy_q) else $error("divider busy while idle");
`endif

endmodule
